// ----- design/ilid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared definitions for the indexed list core
// Sizes, request and status codes, and the command struct that is broadcast
// to every storage cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int CAPACITY = 16;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Index into the store and width of the internal count.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing a request position against the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_HEAD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TAIL   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    // Command seen by every cell in the same cycle.
    typedef struct packed {
        logic ins;
        logic del;
        t_idx pos;
    } t_cell_cmd;

endpackage

// ----- design/ilid_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_req_if / ilid_rsp_if: request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ilid_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ilid_pkg::ACTION_W-1:0]        action;
    logic [ilid_pkg::POS_W-1:0]           position;
    logic signed [ilid_pkg::DATA_W-1:0]   item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface ilid_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ilid_pkg::DATA_W-1:0]   read_value;
    logic [ilid_pkg::STATUS_W-1:0]        status;
    logic [ilid_pkg::COUNT_W-1:0]         count_after;

    modport source (output valid, read_value, status, count_after, input ready);
    modport sink   (input valid, read_value, status, count_after, output ready);
endinterface

// ----- design/ilid_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one storage slot of the shifting store
// Holds one value; on an insert it loads the new value or takes its left
// neighbor, on a delete it takes its right neighbor.
// ----------------------------------------------------------------------------
module ilid_cell (
    input  logic                i_clk,
    input  ilid_pkg::t_idx      i_index,
    input  ilid_pkg::t_cell_cmd i_cmd,
    input  ilid_pkg::t_data     i_new,
    input  ilid_pkg::t_data     i_left,
    input  ilid_pkg::t_data     i_right,
    output ilid_pkg::t_data     o_value
);

    ilid_pkg::t_data r_value;
    ilid_pkg::t_data n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_index == i_cmd.pos) begin
                n_value = i_new;
            end else if (i_index > i_cmd.pos) begin
                n_value = i_left;
            end
        end else if (i_cmd.del && (i_index >= i_cmd.pos)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- design/indexed_list_insert_delete_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core: ordered list with get, insert and delete
// Keeps up to CAPACITY signed values in a row of cells plus a count, and
// answers each request with a read value, a status and the new count.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                               Role
//  i_req     in         action, position, item_value          one request
//  o_rsp     out        read_value, status, count_after       one response
//
// Every request gives exactly one response; a new request can be accepted in
// every cycle unless a response stalls. An insert or delete moves every
// later cell by one place in that same cycle, since each cell loads from its
// neighbor in parallel. The response sits in an output register; a request is
// accepted whenever that register is empty or is being drained, so a stalled
// response holds back only the next request. Reset is synchronous and active
// low; it clears the count and the response valid flag. The cell contents
// are not reset, as only entries below the count are ever read.
//
module indexed_list_insert_delete_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilid_req_if.sink   i_req,
    ilid_rsp_if.source o_rsp
);

    localparam ilid_pkg::t_cnt FULL_CNT = ilid_pkg::CNT_W'(ilid_pkg::CAPACITY);

    // Cell outputs, one per slot.
    ilid_pkg::t_data w_value [ilid_pkg::CAPACITY];

    ilid_pkg::t_cnt  r_count;
    ilid_pkg::t_cnt  n_count;

    logic                             r_out_valid;
    ilid_pkg::t_data                  r_read_value;
    logic [ilid_pkg::STATUS_W-1:0]    r_status;

    ilid_pkg::t_data                  n_read_value;
    logic [ilid_pkg::STATUS_W-1:0]    n_status;
    ilid_pkg::t_cell_cmd              w_cmd;

    logic                             w_accept;
    logic [ilid_pkg::CMP_W-1:0]       w_pos_x;
    logic [ilid_pkg::CMP_W-1:0]       w_cnt_x;
    logic [ilid_pkg::CMP_W-1:0]       w_count_after_x;
    logic                             w_full;

    // The output register accepts a new item when empty or being drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_pos_x = ilid_pkg::CMP_W'(i_req.position);
    assign w_cnt_x = ilid_pkg::CMP_W'(r_count);
    assign w_full  = (r_count == FULL_CNT);

    // Request decode: picks the cell command, the response and the next count.
    always_comb begin
        w_cmd.ins    = 1'b0;
        w_cmd.del    = 1'b0;
        w_cmd.pos    = ilid_pkg::t_idx'(w_pos_x);
        n_read_value = '0;
        n_status     = ilid_pkg::ST_DONE;
        n_count      = r_count;
        case (i_req.action)
            ilid_pkg::ACT_GET: begin
                if (w_pos_x < w_cnt_x) begin
                    n_read_value = w_value[ilid_pkg::t_idx'(w_pos_x)];
                end else begin
                    n_read_value = '1;
                    n_status     = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::ACT_HEAD: begin
                w_cmd.pos = '0;
                if (w_full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilid_pkg::ACT_TAIL: begin
                // The tail position is below CAPACITY whenever it is used.
                w_cmd.pos = ilid_pkg::t_idx'(w_cnt_x);
                if (w_full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilid_pkg::ACT_INSERT: begin
                // The range check comes before the full check.
                if (w_pos_x > w_cnt_x) begin
                    n_status = ilid_pkg::ST_RANGE;
                end else if (w_full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilid_pkg::ACT_DELETE: begin
                if (w_pos_x < w_cnt_x) begin
                    w_cmd.del = 1'b1;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_status = ilid_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = ilid_pkg::ST_RANGE;
            end
        endcase
        // Nothing moves unless the request is actually taken.
        if (!w_accept) begin
            w_cmd.ins = 1'b0;
            w_cmd.del = 1'b0;
        end
    end

    // Row of cells: each slot shifts from its left or right neighbor.
    for (genvar g = 0; g < ilid_pkg::CAPACITY; g++) begin : g_cell
        ilid_pkg::t_data w_left;
        ilid_pkg::t_data w_right;
        if (g == 0) begin : g_first
            assign w_left = i_req.item_value;
        end else begin : g_inner_l
            assign w_left = w_value[g-1];
        end
        if (g == ilid_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_inner_r
            assign w_right = w_value[g+1];
        end
        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_index (ilid_pkg::t_idx'(g)),
            .i_cmd   (w_cmd),
            .i_new   (i_req.item_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    // The reported count is the count truncated to the port width.
    assign w_count_after_x   = ilid_pkg::CMP_W'(r_count);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.status      = r_status;
    assign o_rsp.count_after = w_count_after_x[ilid_pkg::COUNT_W-1:0];

endmodule
